### rtl/mpq_pkg.sv
`timescale 1ns / 1ps
// Package for the max priority queue: field widths, operation and status codes,
// and the entry and cell control types. No dependencies.
package mpq_pkg;

    localparam int DefaultDepth = 8;
    localparam int DataWidth    = 32;
    localparam int OpWidth      = 2;
    localparam int StatusWidth  = 2;
    localparam int FillWidth    = 4;

    typedef logic [OpWidth-1:0]     t_op;
    typedef logic [StatusWidth-1:0] t_status;

    localparam t_op OP_ENQUEUE = 2'd0;
    localparam t_op OP_DEQUEUE = 2'd1;
    localparam t_op OP_PEEK    = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic signed [DataWidth-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

### rtl/mpq_req_if.sv
`timescale 1ns / 1ps
// Request channel of the max priority queue: valid/ready plus the request fields.
// Depends on mpq_pkg.
interface mpq_req_if import mpq_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [OpWidth-1:0]          operation;
    logic signed [DataWidth-1:0] item_value;
    logic signed [DataWidth-1:0] item_priority;

    modport source (output valid, operation, item_value, item_priority, input ready);
    modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

### rtl/mpq_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the max priority queue: valid/ready plus the result fields.
// Depends on mpq_pkg.
interface mpq_rsp_if import mpq_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [StatusWidth-1:0]      status;
    logic signed [DataWidth-1:0] out_value;
    logic signed [DataWidth-1:0] out_priority;
    logic [FillWidth-1:0]        fill_level;

    modport source (output valid, status, out_value, out_priority, fill_level, input ready);
    modport sink   (input valid, status, out_value, out_priority, fill_level, output ready);
endinterface

### rtl/max_priority_queue.sv
`timescale 1ns / 1ps
// Max priority queue built as a sorted chain of cells, top entry in cell 0.
// Result: registered in the cycle after the request is accepted.
// Throughput: one request per cycle unless a result stalls; each cell does one compare and one move a cycle.
// Reset: synchronous, active low; empties the queue and drops any pending result.
// Depends on mpq_pkg, mpq_req_if, mpq_rsp_if and mpq_cell.
module max_priority_queue import mpq_pkg::*; #(
    parameter int QUEUE_DEPTH = DefaultDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpq_req_if.sink    i_req,
    mpq_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_rsp_valid;
    t_status               r_status;
    t_status               n_status;
    logic signed [DataWidth-1:0] r_value;
    logic signed [DataWidth-1:0] r_prio;
    logic signed [DataWidth-1:0] n_value;
    logic signed [DataWidth-1:0] n_prio;

    logic      accept;
    logic      full;
    logic      empty;
    t_cell_ctl ctl;
    t_entry    new_entry;
    t_entry    cell_entry [QUEUE_DEPTH];
    logic      cell_keep  [QUEUE_DEPTH];

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CW'(QUEUE_DEPTH));
    assign empty       = (r_count == '0);

    assign new_entry.value = i_req.item_value;
    assign new_entry.prio  = i_req.item_priority;

    always_comb begin
        ctl      = '0;
        n_count  = r_count;
        n_status = ST_OK;
        n_value  = '0;
        n_prio   = '0;
        case (i_req.operation) inside
            OP_ENQUEUE: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    ctl.insert = accept;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_value = cell_entry[0].value;
                    n_prio  = cell_entry[0].prio;
                    if (i_req.operation == OP_DEQUEUE) begin
                        ctl.remove = accept;
                        n_count    = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_keep;

        if (g == 0) begin : g_head
            assign left_entry = new_entry;
            assign left_keep  = 1'b1;
        end else begin : g_body
            assign left_entry = cell_entry[g-1];
            assign left_keep  = cell_keep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[g];
        end else begin : g_mid
            assign right_entry = cell_entry[g+1];
        end

        mpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (CW'(g) < r_count),
            .i_left_keep (left_keep),
            .i_new       (new_entry),
            .i_left      (left_entry),
            .i_right     (right_entry),
            .o_entry     (cell_entry[g]),
            .o_keep      (cell_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_prio   <= n_prio;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_value    = r_value;
    assign o_rsp.out_priority = r_prio;
    assign o_rsp.fill_level   = FillWidth'(r_count);

endmodule

### rtl/mpq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one entry, compares it with the incoming item,
// and takes its own, the left, the right or the new entry. Depends on mpq_pkg.
module mpq_cell import mpq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  logic      i_left_keep,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_keep
);

    t_entry r_entry;
    t_entry n_entry;

    // keep place when own priority is at least the new one (earlier item wins ties)
    assign o_keep  = i_occupied && ($signed(r_entry.prio) >= $signed(i_new.prio));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.remove) begin
            n_entry = i_right;
        end else if (i_ctl.insert && !o_keep) begin
            n_entry = i_left_keep ? i_new : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### rtl/mpq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the max priority queue, bound to the top level.
// Depends on mpq_pkg and max_priority_queue.
module mpq_checker import mpq_pkg::*; #(
    parameter int QUEUE_DEPTH = DefaultDepth
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [StatusWidth-1:0]      i_status,
    input logic signed [DataWidth-1:0] i_out_value,
    input logic signed [DataWidth-1:0] i_out_priority,
    input logic [FillWidth-1:0]        i_fill_level
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid)
        else $error("no result after accepted item");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_req_ready)
        else $error("item accepted while result is stalled");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (QUEUE_DEPTH < 16) |-> (int'(i_fill_level) <= QUEUE_DEPTH))
        else $error("fill level beyond capacity");

    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_UNDERFLOW)
            |-> (i_out_value == '0) && (i_out_priority == '0) && (i_fill_level == '0))
        else $error("underflow result not zero");

endmodule

bind max_priority_queue mpq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mpq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_value    (o_rsp.out_value),
    .i_out_priority (o_rsp.out_priority),
    .i_fill_level   (o_rsp.fill_level)
);
